FILE: rtl/core/apc_pkg.sv
// Shared constants of the averaged pressure converter: register map, reset values,
// result limits and the quotient width of the serial divider.
// No dependencies; used by apc_serial_div and averaged_pressure_converter_core.
package apc_pkg;

  // Fixed field widths.
  localparam int unsigned SUPPLY_W   = 12;
  localparam int unsigned WINDOW_W   = 6;
  localparam int unsigned USED_W     = 6;
  localparam int unsigned PRESS_W    = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  // Quotient bits produced by one pass of the serial divider.
  localparam int unsigned QUO_W = 17;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_WINDOW_LEN   = 2'd0;
  localparam logic [1:0] REG_AVERAGE_MODE = 2'd1;
  localparam logic [1:0] REG_SUPPLY_CODE  = 2'd2;

  // Averaging modes.
  localparam logic MODE_ROLLING = 1'b0;
  localparam logic MODE_BLOCK   = 1'b1;

  // Register reset values.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd8;
  localparam logic                MODE_RESET   = MODE_ROLLING;
  localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 12'd1667;

  // Pressure limits in Q8 and the matching quotient magnitudes.
  localparam logic signed [PRESS_W-1:0] Q8_HIGH = 16'sd32767;
  localparam logic signed [PRESS_W-1:0] Q8_LOW  = -16'sd1200;
  localparam logic [QUO_W-1:0] POS_MAG_MAX = 17'd32767;
  localparam logic [QUO_W-1:0] NEG_MAG_MAX = 17'd1200;

endpackage

FILE: rtl/core/apc_serial_div.sv
// Restoring divider that produces one quotient bit per cycle, apc_pkg::QUO_W bits in all.
// Depends on apc_pkg for the quotient width.
module apc_serial_div #(
  parameter int unsigned DVD_W = 36,
  parameter int unsigned DIV_W = 22
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DVD_W-1:0]            dividend_i,
  input  logic [DIV_W-1:0]            divisor_i,
  output logic                        busy_o,
  output logic [apc_pkg::QUO_W-1:0]   quotient_o
);

  localparam int unsigned QW    = apc_pkg::QUO_W;
  localparam int unsigned STEP_W = $clog2(QW);
  localparam int unsigned CMP_W = (DVD_W > DIV_W) ? DVD_W : DIV_W;

  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  rem_d;
  logic [DIV_W-1:0]  div_q;
  logic [QW-1:0]     quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    trial_sub;
  logic              fits;

  // The partial remainder stays below the divisor, so one extra bit holds the trial value.
  assign trial     = {rem_q, quo_q[QW-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign fits      = (trial >= {1'b0, div_q});
  assign rem_d     = fits ? DIV_W'(trial_sub) : DIV_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(QW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The high part of the dividend is the starting remainder; the low part shifts
  // out at the top of the quotient register while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIV_W'(dividend_i >> QW);
      quo_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while a division is running");

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ((CMP_W'(dividend_i) >> QW) < CMP_W'(divisor_i)))
    else $error("quotient does not fit the divider width");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (divisor_i != '0))
    else $error("divider started with a zero divisor");

endmodule

FILE: rtl/core/averaged_pressure_converter_core.sv
// Averaged pressure converter: boxcar averaging of ratiometric sensor ADC codes and
// conversion of the mean to signed Q8 kPa. Depends on apc_pkg and apc_serial_div.
//
//  Channel  | Direction | Handshake                      | Payload
//  ---------+-----------+--------------------------------+-----------------------------------
//  config   | in/out    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//  input    | in        | in_valid_i, in_stall_o         | sample_code_i
//  output   | out       | out_valid_o, out_stall_i       | pressure_q8_o, samples_used_o,
//           |           |                                | mean_code_o, saturated_o
//
// Sequence: a rolling-mode sample passes the sum, mean division, preparation, check, quotient
// division and output states before the block takes the next one; a block-mode sample that
// completes a window skips the sum state, and one that completes none stays in idle. A mean
// that saturates early skips the second division. Both divisions use the shared serial divider.
// Reset clears the configuration to its defaults and empties the averaging history; the
// sample ring needs no clearing because the fill count guards every read of it.
// A stalled output holds its result; the next input transfer is still taken while it waits,
// and the sequencer only waits once the following result is ready.
module averaged_pressure_converter_core #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [apc_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [apc_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [apc_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready,
  // Input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [SAMPLE_BITS-1:0]                sample_code_i,
  // Output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [apc_pkg::PRESS_W-1:0]    pressure_q8_o,
  output logic [apc_pkg::USED_W-1:0]            samples_used_o,
  output logic [SAMPLE_BITS-1:0]                mean_code_o,
  output logic                                  saturated_o
);

  // Widths that follow from the window depth and the sample width.
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int unsigned K_W     = SUM_W + 10;
  localparam int unsigned SN_W    = apc_pkg::SUPPLY_W + CNT_W;
  localparam int unsigned SN40_W  = SN_W + 6;
  localparam int unsigned MAG_W   = (K_W > SN40_W) ? K_W : SN40_W;
  localparam int unsigned DIFF_W  = MAG_W + 1;
  localparam int unsigned NUM_W   = MAG_W + 8;
  localparam int unsigned DEN_W   = SN_W + 4;
  localparam int unsigned WCMP_W  = (CNT_W > apc_pkg::WINDOW_W) ? CNT_W : apc_pkg::WINDOW_W;
  localparam int unsigned CHK_W   = (NUM_W > DEN_W + apc_pkg::QUO_W) ? NUM_W
                                                                      : DEN_W + apc_pkg::QUO_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SUM    = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MDIV   = 4'd3;
  localparam logic [3:0] S_PREP1  = 4'd4;
  localparam logic [3:0] S_PREP2  = 4'd5;
  localparam logic [3:0] S_PREP3  = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_QDIV   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // ------------------------------------------------------------------------------------
  // Configuration registers. Writing the window length or the mode empties the history.
  // ------------------------------------------------------------------------------------
  logic [apc_pkg::WINDOW_W-1:0] window_q;
  logic                         mode_q;
  logic [apc_pkg::SUPPLY_W-1:0] supply_q;
  logic                         cfg_we;
  logic [1:0]                   cfg_idx;
  logic                         clear_hist;

  assign pready     = 1'b1;
  assign cfg_idx    = paddr[3:2];
  assign cfg_we     = psel && penable && pwrite;
  assign clear_hist = cfg_we && ((cfg_idx == apc_pkg::REG_WINDOW_LEN) ||
                                 (cfg_idx == apc_pkg::REG_AVERAGE_MODE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= apc_pkg::WINDOW_RESET;
      mode_q   <= apc_pkg::MODE_RESET;
      supply_q <= apc_pkg::SUPPLY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        apc_pkg::REG_WINDOW_LEN:   window_q <= pwdata[apc_pkg::WINDOW_W-1:0];
        apc_pkg::REG_AVERAGE_MODE: mode_q   <= pwdata[0];
        apc_pkg::REG_SUPPLY_CODE:  supply_q <= pwdata[apc_pkg::SUPPLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      apc_pkg::REG_WINDOW_LEN:   prdata = apc_pkg::CFG_DATA_W'(window_q);
      apc_pkg::REG_AVERAGE_MODE: prdata = apc_pkg::CFG_DATA_W'(mode_q);
      apc_pkg::REG_SUPPLY_CODE:  prdata = apc_pkg::CFG_DATA_W'(supply_q);
      default:                   prdata = '0;
    endcase
  end

  // The effective window is the register value clamped to one and to the ring depth.
  logic [CNT_W-1:0]             w_eff;
  logic [apc_pkg::SUPPLY_W-1:0] s_eff;

  always_comb begin
    if (window_q == '0) begin
      w_eff = CNT_W'(1);
    end else if (WCMP_W'(window_q) > WCMP_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(window_q);
    end
  end

  // A supply code of zero counts as one.
  assign s_eff = (supply_q == '0) ? apc_pkg::SUPPLY_W'(1) : supply_q;

  // ------------------------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------------------------
  logic [3:0] state_q;
  logic [3:0] state_d;
  logic       in_acc;
  logic       out_free;
  logic       out_valid_q;
  logic       over;
  logic       div_start;
  logic       div_busy;
  logic [apc_pkg::QUO_W-1:0] div_quo;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // History bookkeeping for the transfer being accepted.
  logic [SLOT_W-1:0] write_slot_q;
  logic [CNT_W-1:0]  fill_q;
  logic [SUM_W-1:0]  window_sum_q;
  logic [SUM_W-1:0]  block_sum_q;
  logic [CNT_W-1:0]  block_count_q;
  logic              replace;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W-1:0]  slot_p1;
  logic [SLOT_W-1:0] slot_next;
  logic [CNT_W-1:0]  bcount_inc;
  logic [SUM_W-1:0]  bsum_add;
  logic              block_done;

  assign replace    = (fill_q >= w_eff);
  assign fill_inc   = fill_q + CNT_W'(1);
  assign slot_p1    = CNT_W'(write_slot_q) + CNT_W'(1);
  assign slot_next  = (slot_p1 >= w_eff) ? '0 : SLOT_W'(slot_p1);
  assign bcount_inc = block_count_q + CNT_W'(1);
  assign bsum_add   = block_sum_q + SUM_W'(sample_code_i);
  assign block_done = (bcount_inc >= w_eff);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mode_q == apc_pkg::MODE_ROLLING) begin
            state_d = S_SUM;
          end else if (block_done) begin
            state_d = S_MSTART;
          end
        end
      end
      S_SUM:    state_d = S_MSTART;
      S_MSTART: state_d = S_MDIV;
      S_MDIV:   state_d = div_busy ? S_MDIV : S_PREP1;
      S_PREP1:  state_d = S_PREP2;
      S_PREP2:  state_d = S_PREP3;
      S_PREP3:  state_d = S_CHECK;
      S_CHECK:  state_d = over ? S_OUT : S_QDIV;
      S_QDIV:   state_d = div_busy ? S_QDIV : S_OUT;
      S_OUT:    state_d = out_free ? S_IDLE : S_OUT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------------------------------
  // Sample ring. The entry at the write slot is read and overwritten in the same cycle,
  // so the registered read returns the sample that leaves the window.
  // ------------------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] ring_rd_q;
  logic                   ring_we;

  assign ring_we = in_acc && (mode_q == apc_pkg::MODE_ROLLING);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[write_slot_q] <= sample_code_i;
      ring_rd_q              <= ring_mem[write_slot_q];
    end
  end

  // ------------------------------------------------------------------------------------
  // Datapath registers
  // ------------------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]   code_q;
  logic                     replace_q;
  logic [SUM_W-1:0]         dsum_q;
  logic [CNT_W-1:0]         dn_q;
  logic [CNT_W-1:0]         used_q;
  logic [SAMPLE_BITS-1:0]   mean_q;
  logic [SUM_W-1:0]         esum_q;
  logic [CNT_W-1:0]         en_q;
  logic [SN_W-1:0]          sn_q;
  logic [K_W-1:0]           k_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [DEN_W-1:0]         den_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q;
  logic signed [apc_pkg::PRESS_W-1:0] press_q;
  logic                     sat_q;

  logic [SUM_W-1:0]   wsum_new;
  logic [SN40_W-1:0]  sn40;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   div_dvd;
  logic [DEN_W-1:0]   div_dvs;
  logic signed [apc_pkg::PRESS_W-1:0] press_div;
  logic               sat_div;

  // Rolling sum: add the new sample, and drop the oldest once the window is full.
  assign wsum_new = replace_q ? (window_sum_q - SUM_W'(ring_rd_q) + SUM_W'(code_q))
                              : (window_sum_q + SUM_W'(code_q));

  // 40 * S * n and the Q8 numerator magnitude.
  assign sn40 = (SN40_W'(sn_q) << 5) + (SN40_W'(sn_q) << 3);
  assign num  = {mag_q, 8'd0};

  // Saturation is certain when the quotient would need more bits than the divider gives.
  assign over = (CHK_W'(num) >= (CHK_W'(den_q) << apc_pkg::QUO_W));

  // The divider is shared: first the mean code, then the pressure quotient.
  assign div_start = (state_q == S_MSTART) || ((state_q == S_CHECK) && !over);
  assign div_dvd   = (state_q == S_CHECK) ? num : NUM_W'(dsum_q);
  assign div_dvs   = (state_q == S_CHECK) ? den_q : DEN_W'(dn_q);

  // Quotient magnitude to signed Q8 with clamping; truncation is toward zero.
  always_comb begin
    press_div = apc_pkg::Q8_HIGH;
    sat_div   = 1'b0;
    if (neg_q) begin
      if (div_quo > apc_pkg::NEG_MAG_MAX) begin
        press_div = apc_pkg::Q8_LOW;
        sat_div   = 1'b1;
      end else begin
        press_div = 16'sd0 - $signed(apc_pkg::PRESS_W'(div_quo));
      end
    end else begin
      if (div_quo > apc_pkg::POS_MAG_MAX) begin
        press_div = apc_pkg::Q8_HIGH;
        sat_div   = 1'b1;
      end else begin
        press_div = $signed(apc_pkg::PRESS_W'(div_quo));
      end
    end
  end

  apc_serial_div #(
    .DVD_W (NUM_W),
    .DIV_W (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // History state, cleared on reset and on a window or mode write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q  <= '0;
      fill_q        <= '0;
      window_sum_q  <= '0;
      block_sum_q   <= '0;
      block_count_q <= '0;
    end else if (clear_hist) begin
      write_slot_q  <= '0;
      fill_q        <= '0;
      window_sum_q  <= '0;
      block_sum_q   <= '0;
      block_count_q <= '0;
    end else if (in_acc) begin
      if (mode_q == apc_pkg::MODE_ROLLING) begin
        write_slot_q <= slot_next;
        if (!replace) begin
          fill_q <= fill_inc;
        end
      end else if (block_done) begin
        block_sum_q   <= '0;
        block_count_q <= '0;
      end else begin
        block_sum_q   <= bsum_add;
        block_count_q <= bcount_inc;
      end
    end else if (state_q == S_SUM) begin
      window_sum_q <= wsum_new;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          code_q    <= sample_code_i;
          replace_q <= replace;
          if (mode_q == apc_pkg::MODE_ROLLING) begin
            dn_q   <= replace ? fill_q : fill_inc;
            used_q <= replace ? fill_q : fill_inc;
          end else begin
            dsum_q <= bsum_add;
            dn_q   <= w_eff;
            used_q <= bcount_inc;
          end
        end
      end
      S_SUM: begin
        dsum_q <= wsum_new;
      end
      S_MDIV: begin
        // In block mode the truncated mean is converted as a single sample.
        mean_q <= SAMPLE_BITS'(div_quo);
        if (mode_q == apc_pkg::MODE_BLOCK) begin
          esum_q <= SUM_W'(div_quo[SAMPLE_BITS-1:0]);
          en_q   <= CNT_W'(1);
        end else begin
          esum_q <= dsum_q;
          en_q   <= dn_q;
        end
      end
      S_PREP1: begin
        sn_q <= SN_W'(s_eff) * SN_W'(en_q);
        k_q  <= (K_W'(esum_q) << 10) - (K_W'(esum_q) << 4) - (K_W'(esum_q) << 3);
      end
      S_PREP2: begin
        diff_q <= $signed(DIFF_W'(k_q)) - $signed(DIFF_W'(sn40));
        den_q  <= (DEN_W'(sn_q) << 3) + DEN_W'(sn_q);
      end
      S_PREP3: begin
        neg_q <= diff_q[DIFF_W-1];
        mag_q <= diff_q[DIFF_W-1] ? MAG_W'(-diff_q) : MAG_W'(diff_q);
      end
      S_CHECK: begin
        if (over) begin
          press_q <= neg_q ? apc_pkg::Q8_LOW : apc_pkg::Q8_HIGH;
          sat_q   <= 1'b1;
        end
      end
      S_QDIV: begin
        if (!div_busy) begin
          press_q <= press_div;
          sat_q   <= sat_div;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------------------------
  logic signed [apc_pkg::PRESS_W-1:0] pressure_q;
  logic [apc_pkg::USED_W-1:0]         used_out_q;
  logic [SAMPLE_BITS-1:0]             mean_out_q;
  logic                               sat_out_q;
  logic                               out_load;

  assign out_load = (state_q == S_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pressure_q <= press_q;
      used_out_q <= apc_pkg::USED_W'(used_q);
      mean_out_q <= mean_q;
      sat_out_q  <= sat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pressure_q8_o  = pressure_q;
  assign samples_used_o = used_out_q;
  assign mean_code_o    = mean_out_q;
  assign saturated_o    = sat_out_q;

  // ------------------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------------------
  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= w_eff) && (CNT_W'(write_slot_q) < w_eff))
    else $error("rolling history runs past the window");

  a_block_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_count_q < w_eff)
    else $error("block count reached the window without a result");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside the output state");

endmodule
